/* hdl/hsv_to_rgb_converter_core_assert.svh */
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property forms for the converter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define HSVRGB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hsvrgb: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hsvrgb: next-cycle check failed");

`endif

/* hdl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Constants, sextant codes, types and helpers shared by the converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int HUE_W   = 13;
	localparam int LEVEL_W = 9;
	localparam int BYTE_W  = 8;
	localparam int SEXT_W  = 4;
	localparam int REM_W   = 10;
	localparam int FRAC_W  = 8;

	localparam logic [HUE_W-1:0]   HUE_FULL     = 13'd5760;
	localparam logic [HUE_W-1:0]   SEXTANT_SPAN = 13'd960;
	localparam logic [LEVEL_W-1:0] Q_ONE        = 9'd256;
	// ceil(2^16 / 15): (rem*4)/15 == (rem*4*RECIP_15) >> 16 for rem < 960
	localparam logic [12:0]        RECIP_15     = 13'd4370;
	localparam int                 NUM_SPLITS   = 8;

	localparam logic [SEXT_W-1:0] SEXT_RED_YEL = 4'd0;
	localparam logic [SEXT_W-1:0] SEXT_YEL_GRN = 4'd1;
	localparam logic [SEXT_W-1:0] SEXT_GRN_CYN = 4'd2;
	localparam logic [SEXT_W-1:0] SEXT_CYN_BLU = 4'd3;
	localparam logic [SEXT_W-1:0] SEXT_BLU_MAG = 4'd4;
	localparam logic [SEXT_W-1:0] SEXT_MAG_RED = 4'd5;

	typedef struct packed {
		logic [SEXT_W-1:0] sext;
		logic [REM_W-1:0]  rem;
	} hue_split_t;

	// (L*255) >> 8, done as (L*256 - L) >> 8
	function automatic logic [BYTE_W-1:0] to_byte(input logic [LEVEL_W-1:0] lvl);
		logic [16:0] m;
		m = {lvl, 8'b0} - {8'b0, lvl};
		return m[15:8];
	endfunction

endpackage

/* hdl/hsvrgb_hue_split.sv */
// ----------------------------------------------------------------------------
// HSV to RGB hue splitter
// Wraps a full-turn hue to zero and splits it into sextant and remainder.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split import hsvrgb_pkg::*; (
	input  logic [HUE_W-1:0] hue,
	output hue_split_t       split
);

	logic [HUE_W-1:0]      hue_w;
	logic [NUM_SPLITS-1:0] above;
	logic [HUE_W-1:0]      base;
	logic [HUE_W-1:0]      diff;

	assign hue_w = (hue == HUE_FULL) ? '0 : hue;

	// thermometer of sextant boundaries; count gives hue / 960
	always_comb begin
		for (int k = 0; k < NUM_SPLITS; k++) begin
			above[k] = (hue_w >= HUE_W'((k + 1) * SEXTANT_SPAN));
		end
	end

	assign split.sext = SEXT_W'($countones(above));

	always_comb begin
		base = '0;
		for (int k = 0; k < NUM_SPLITS; k++) begin
			if (above[k]) begin
				base = HUE_W'((k + 1) * SEXTANT_SPAN);
			end
		end
	end

	assign diff       = hue_w - base;
	assign split.rem  = diff[REM_W-1:0];

endmodule

/* hdl/hsv_to_rgb_converter_core.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Five-stage pipeline turning hue/saturation/brightness into 8-bit RGB.
// ----------------------------------------------------------------------------
// Input channel: hsv_valid/hsv_ready carry one word of hue (1/16 degree,
// 5760 wraps to 0, a hue past the wheel gives black unless saturation is 0),
// saturation and brightness (Q1.8, values above 256 clamp to 256).
// Output channel: rgb_valid/rgb_ready carry one word of red, green, blue.
// An accepted word moves through the stage registers in order; rgb_valid is
// the valid bit of the final register.
// Throughput: one word per cycle unless stalled; stages are hue split, fraction
// and p product, s*f products, q/t products, then channel select and byte scale.
// Each stage holds a valid bit and advances when the stage after it is empty
// or moving, so bubbles are squeezed out and a stall loses nothing.
// When the receiver stalls the final register holds its word and the stages
// behind it keep filling; hsv_ready drops only once all five are full.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_assert.svh"

module hsv_to_rgb_converter_core import hsvrgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsv_valid,
	output logic               hsv_ready,
	input  logic [HUE_W-1:0]   hue,
	input  logic [LEVEL_W-1:0] saturation,
	input  logic [LEVEL_W-1:0] brightness,
	output logic               rgb_valid,
	input  logic               rgb_ready,
	output logic [BYTE_W-1:0]  red,
	output logic [BYTE_W-1:0]  green,
	output logic [BYTE_W-1:0]  blue
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5     = !vld_s5 || rgb_ready;
	assign en_s4     = !vld_s4 || en_s5;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign hsv_ready = en_s1;
	assign rgb_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= hsv_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// ---- stage 1: clamp, hue split
	hue_split_t         split;
	logic [LEVEL_W-1:0] sat_c, val_c;

	hsvrgb_hue_split u_hue_split (
		.hue   (hue),
		.split (split)
	);

	assign sat_c = (saturation > Q_ONE) ? Q_ONE : saturation;
	assign val_c = (brightness > Q_ONE) ? Q_ONE : brightness;

	logic [SEXT_W-1:0]  sext_s1;
	logic [REM_W-1:0]   rem_s1;
	logic [LEVEL_W-1:0] sat_s1, val_s1;
	logic               grey_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sext_s1 <= split.sext;
			rem_s1  <= split.rem;
			sat_s1  <= sat_c;
			val_s1  <= val_c;
			grey_s1 <= (sat_c == '0);
		end
	end

	// ---- stage 2: fraction = rem*256/960 = (rem*4)/15, and p
	logic [24:0]        frac_prod;
	logic [17:0]        p_prod;
	logic [LEVEL_W-1:0] inv_sat;

	assign frac_prod = {1'b0, rem_s1, 2'b00} * {12'b0, RECIP_15};
	assign inv_sat   = Q_ONE - sat_s1;
	assign p_prod    = {9'b0, val_s1} * {9'b0, inv_sat};

	logic [SEXT_W-1:0]  sext_s2;
	logic [FRAC_W-1:0]  frac_s2;
	logic [LEVEL_W-1:0] sat_s2, val_s2, p_s2;
	logic               grey_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sext_s2 <= sext_s1;
			frac_s2 <= frac_prod[23:16];
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
			p_s2    <= p_prod[16:8];
			grey_s2 <= grey_s1;
		end
	end

	// ---- stage 3: s*f and s*(256-f)
	logic [LEVEL_W-1:0] inv_frac;
	logic [17:0]        sf_prod, snf_prod;

	assign inv_frac = Q_ONE - {1'b0, frac_s2};
	assign sf_prod  = {9'b0, sat_s2} * {10'b0, frac_s2};
	assign snf_prod = {9'b0, sat_s2} * {9'b0, inv_frac};

	logic [SEXT_W-1:0]  sext_s3;
	logic [16:0]        sf_s3, snf_s3;
	logic [LEVEL_W-1:0] val_s3, p_s3;
	logic               grey_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sext_s3 <= sext_s2;
			sf_s3   <= sf_prod[16:0];
			snf_s3  <= snf_prod[16:0];
			val_s3  <= val_s2;
			p_s3    <= p_s2;
			grey_s3 <= grey_s2;
		end
	end

	// ---- stage 4: q and t
	logic [17:0] q_wt, t_wt;
	logic [25:0] q_prod, t_prod;

	assign q_wt   = 18'h10000 - {1'b0, sf_s3};
	assign t_wt   = 18'h10000 - {1'b0, snf_s3};
	assign q_prod = {17'b0, val_s3} * {9'b0, q_wt[16:0]};
	assign t_prod = {17'b0, val_s3} * {9'b0, t_wt[16:0]};

	logic [SEXT_W-1:0]  sext_s4;
	logic [LEVEL_W-1:0] val_s4, p_s4, q_s4, t_s4;
	logic               grey_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sext_s4 <= sext_s3;
			val_s4  <= val_s3;
			p_s4    <= p_s3;
			q_s4    <= q_prod[24:16];
			t_s4    <= t_prod[24:16];
			grey_s4 <= grey_s3;
		end
	end

	// ---- stage 5: channel select and byte scale
	logic [LEVEL_W-1:0] r_lvl, g_lvl, b_lvl;

	always_comb begin
		if (grey_s4) begin
			r_lvl = val_s4;
			g_lvl = val_s4;
			b_lvl = val_s4;
		end else begin
			case (sext_s4)
				SEXT_RED_YEL: begin r_lvl = val_s4; g_lvl = t_s4;   b_lvl = p_s4;   end
				SEXT_YEL_GRN: begin r_lvl = q_s4;   g_lvl = val_s4; b_lvl = p_s4;   end
				SEXT_GRN_CYN: begin r_lvl = p_s4;   g_lvl = val_s4; b_lvl = t_s4;   end
				SEXT_CYN_BLU: begin r_lvl = p_s4;   g_lvl = q_s4;   b_lvl = val_s4; end
				SEXT_BLU_MAG: begin r_lvl = t_s4;   g_lvl = p_s4;   b_lvl = val_s4; end
				SEXT_MAG_RED: begin r_lvl = val_s4; g_lvl = p_s4;   b_lvl = q_s4;   end
				default: begin
					// hue past the wheel: black
					r_lvl = '0;
					g_lvl = '0;
					b_lvl = '0;
				end
			endcase
		end
	end

	logic [BYTE_W-1:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			red_s5   <= to_byte(r_lvl);
			green_s5 <= to_byte(g_lvl);
			blue_s5  <= to_byte(b_lvl);
		end
	end

	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

	// ---- checks
	`HSVRGB_ASSERT_IMPL(a_rem_in_span, clk, arst_n, vld_s1, rem_s1 < SEXTANT_SPAN[REM_W-1:0])
	`HSVRGB_ASSERT_IMPL(a_levels_le_one, clk, arst_n, vld_s4, (q_s4 <= Q_ONE) && (t_s4 <= Q_ONE) && (p_s4 <= Q_ONE))
	`HSVRGB_ASSERT_NEXT(a_grey_equal, clk, arst_n, vld_s4 && en_s5 && grey_s4, (red == green) && (green == blue))
	`HSVRGB_ASSERT_NEXT(a_off_wheel_black, clk, arst_n, vld_s4 && en_s5 && !grey_s4 && (sext_s4 > SEXT_MAG_RED), (red == '0) && (green == '0) && (blue == '0))

endmodule

/* tb/tb_hsv_to_rgb_converter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Drives hue/saturation/brightness words through the valid/ready input,
// predicts each RGB word in the bench and checks every output word in order.
// Covers extremes, sextant edges, hue wrap and past-wheel black, grey and
// clamped levels, random traffic under idle/stall mixes, and output hold-off.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_core;
	import hsvrgb_pkg::*;

	localparam int PIPE_LATENCY   = 5;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int RANDOM_WORDS   = 450;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_word_t;

	logic               clk;
	logic               arst_n;
	logic               hsv_valid;
	logic               hsv_ready;
	logic [HUE_W-1:0]   hue;
	logic [LEVEL_W-1:0] saturation;
	logic [LEVEL_W-1:0] brightness;
	logic               rgb_valid;
	logic               rgb_ready;
	logic [BYTE_W-1:0]  red;
	logic [BYTE_W-1:0]  green;
	logic [BYTE_W-1:0]  blue;

	rgb_word_t rgb_expect_q[$];
	int        fail_count;
	int        send_idle_pct;
	int        rx_stall_pct;
	logic      rx_hold_go;
	int        rx_hold_left;

	hsv_to_rgb_converter_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Q1.8 level to output byte, L*255/256 truncated
	function automatic logic [BYTE_W-1:0] level_to_byte(input int unsigned lvl);
		int unsigned scaled;
		scaled = (lvl * 255) >> 8;
		return scaled[BYTE_W-1:0];
	endfunction

	function automatic rgb_word_t hsv_to_rgb_predict(input logic [HUE_W-1:0] h_in,
			input logic [LEVEL_W-1:0] s_in, input logic [LEVEL_W-1:0] v_in);
		int unsigned h, s, v, frac, p, q, t, r, g, b;
		logic [SEXT_W-1:0] sext;
		rgb_word_t res;
		h = {19'b0, h_in};
		s = (s_in > 256) ? 256 : {23'b0, s_in};
		v = (v_in > 256) ? 256 : {23'b0, v_in};
		if (s == 0) begin
			r = v;
			g = v;
			b = v;
		end else begin
			if (h == 5760)
				h = 0;
			sext = SEXT_W'(h / 960);
			frac = ((h % 960) * 256) / 960;
			p = (v * (256 - s)) >> 8;
			q = (v * (65536 - s * frac)) >> 16;
			t = (v * (65536 - s * (256 - frac))) >> 16;
			case (sext)
				SEXT_RED_YEL: begin r = v; g = t; b = p; end
				SEXT_YEL_GRN: begin r = q; g = v; b = p; end
				SEXT_GRN_CYN: begin r = p; g = v; b = t; end
				SEXT_CYN_BLU: begin r = p; g = q; b = v; end
				SEXT_BLU_MAG: begin r = t; g = p; b = v; end
				SEXT_MAG_RED: begin r = v; g = p; b = q; end
				default: begin r = 0; g = 0; b = 0; end
			endcase
		end
		res.red   = level_to_byte(r);
		res.green = level_to_byte(g);
		res.blue  = level_to_byte(b);
		return res;
	endfunction

	// receiver: random stalls, or a long hold-off counted down here
	always @(posedge clk) begin
		if (rx_hold_go && rx_hold_left == 0) begin
			rx_hold_left = RX_HOLD_CYCLES;
			rgb_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			rgb_ready <= 1'b0;
		end else begin
			rgb_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// record accepted input words, then check accepted output words
	always @(posedge clk) begin
		rgb_word_t want;
		if (arst_n) begin
			if (hsv_valid && hsv_ready)
				rgb_expect_q.push_back(hsv_to_rgb_predict(hue, saturation, brightness));
			if (rgb_valid && rgb_ready) begin
				if (rgb_expect_q.size() == 0) begin
					$error("unexpected output word: red %0d green %0d blue %0d",
						red, green, blue);
					fail_count++;
				end else begin
					want = rgb_expect_q.pop_front();
					if (red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, red);
						fail_count++;
					end
					if (green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, green);
						fail_count++;
					end
					if (blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, blue);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic send_hsv(input logic [HUE_W-1:0] h, input logic [LEVEL_W-1:0] s,
			input logic [LEVEL_W-1:0] v);
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			hsv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do @(posedge clk); while (!hsv_ready);
	endtask

	// drop valid so the last accepted word is not accepted again
	task automatic end_burst();
		hsv_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		end_burst();
		while (rgb_expect_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		send_hsv(0, 256, 256);
		send_hsv(5759, 256, 256);
		send_hsv(5760, 256, 256);      // full circle wraps to red
		send_hsv(5761, 256, 256);      // past the wheel: black
		send_hsv(8191, 511, 511);
		send_hsv(8191, 0, 200);        // past the wheel but grey
		send_hsv(959, 256, 256);
		send_hsv(960, 256, 256);
		send_hsv(1440, 256, 256);
		send_hsv(2400, 200, 180);
		send_hsv(3360, 128, 256);
		send_hsv(4320, 256, 100);
		send_hsv(5280, 64, 256);
		send_hsv(1234, 0, 256);        // grey, full level
		send_hsv(4000, 0, 0);
		send_hsv(0, 0, 0);
		send_hsv(700, 257, 257);       // clamp both levels
		send_hsv(3000, 511, 128);
		send_hsv(4500, 128, 511);
		send_hsv(2000, 1, 1);
		send_hsv(1919, 255, 255);
		send_hsv(5000, 256, 0);
		send_hsv(2880, 300, 256);
		wait_for_results();
	endtask

	task automatic test_random(input int n_words, input int idle_pct, input int stall_pct);
		logic [HUE_W-1:0]   h;
		logic [LEVEL_W-1:0] s, v;
		int pick;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		repeat (n_words) begin
			pick = int'($urandom_range(9));
			if (pick == 0)
				h = HUE_W'(960 * $urandom_range(6) - $urandom_range(1));
			else if (pick == 1)
				h = HUE_W'($urandom_range(8191));
			else
				h = HUE_W'($urandom_range(5760));
			pick = int'($urandom_range(9));
			s = (pick == 0) ? '0 : (pick == 1) ? LEVEL_W'($urandom_range(511)) :
				LEVEL_W'($urandom_range(256));
			pick = int'($urandom_range(9));
			v = (pick == 0) ? '0 : (pick == 1) ? LEVEL_W'($urandom_range(511)) :
				LEVEL_W'($urandom_range(256));
			send_hsv(h, s, v);
		end
		wait_for_results();
	endtask

	// receiver holds off while words keep coming, so the pipe fills and stalls input
	task automatic test_output_hold();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		rx_hold_go <= 1'b1;
		@(posedge clk);
		rx_hold_go <= 1'b0;
		repeat (30)
			send_hsv(HUE_W'($urandom_range(8191)), LEVEL_W'($urandom_range(511)),
				LEVEL_W'($urandom_range(511)));
		wait_for_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		hsv_valid     = 1'b0;
		hue           = '0;
		saturation    = '0;
		brightness    = '0;
		rgb_ready     = 1'b0;
		rx_hold_go    = 1'b0;
		rx_hold_left  = 0;
		fail_count    = 0;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(RANDOM_WORDS, 0, 0);
		test_random(RANDOM_WORDS, 87, 0);
		test_random(RANDOM_WORDS, 0, 87);
		test_random(RANDOM_WORDS, 23, 23);
		test_output_hold();

		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_hue_split.sv
hdl/hsv_to_rgb_converter_core.sv
tb/tb_hsv_to_rgb_converter_core.sv
